// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL files of the string unescaper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, switched off while reset is held.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/jsu_pkg.sv =====
// Shared types, constants and helper functions of the string unescaper.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);
    localparam int MAX_RES   = 8;
    localparam int RES_IDX_W = $clog2(MAX_RES);
    localparam int RES_CNT_W = $clog2(MAX_RES + 1);

    typedef logic [1:0] t_end;
    localparam t_end END_NONE  = 2'd0;
    localparam t_end END_QUOTE = 2'd1;
    localparam t_end END_ZERO  = 2'd2;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;

    // One accepted input byte expands into this bundle of up to eight result bytes.
    // When ekind is not END_NONE the final entry is a status-only result.
    typedef struct packed {
        logic [MAX_RES-1:0][7:0] data;
        logic [RES_CNT_W-1:0]    cnt;
        t_end                    ekind;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef struct packed {
        logic       valid;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_digit(input logic [7:0] c);
        t_hex h;
        h.valid = 1'b1;
        h.val   = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.val = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.val = 4'(c - 8'h37);
        end else begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/json_string_unescape_utf8.sv =====
// Top level of the JSON string unescaper with UTF-8 output.
//
// Usage: the input stream carries the raw content bytes of a JSON string,
// one byte per request; tuser is high on the first byte after the opening
// quote and clears any pending escape. The output stream carries the decoded
// UTF-8 bytes. An unescaped quote or a zero byte ends the string with a
// status-only result (tuser has_byte low, end kind in tuser[2:1]); bytes
// that arrive after that, without tuser, are dropped silently.
// tlast marks the final result produced by each input byte. Bytes that are
// only absorbed (a backslash, a hex digit) produce no result at all.
//
// Timing: an input byte is decoded in the cycle it is accepted; its results
// are registered in the queue and then in the output register.
// The output side emits one result per cycle while the receiver is ready, so a
// plain byte passes at one request per cycle; a byte that expands into more than
// one result holds the output until its last result has gone.
// A four-entry queue parts the decoder from the output sequencer. While the
// receiver stalls the queue fills and the input is held off only once it is
// full. Reset clears the queue, the output register and the decoder, which
// starts idle and waits for a byte flagged as the start of a string.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module json_string_unescape_utf8 (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  wire logic       i_s_axis_tuser,   // [0] begin_req
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata,   // [7:0] out_byte
    output logic [2:0]      o_m_axis_tuser,   // [0] has_byte, [2:1] end_kind
    output logic            o_m_axis_tlast    // last
);
    import jsu_pkg::*;

    t_cmd   w_push_cmd;
    t_cmd   w_head;
    t_qstat w_qstat;
    logic   w_push;
    logic   w_pop;
    logic   w_has;
    t_end   w_end;

    // Decoder: escape state machine, produces one bundle per accepted byte that yields results.
    jsu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_byte  (i_s_axis_tdata),
        .i_begin (i_s_axis_tuser),
        .i_qstat (w_qstat),
        .o_ready (o_s_axis_tready),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    // Bundles wait here so that a stalled receiver does not stall decoding at once.
    jsu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_qstat (w_qstat)
    );

    // Output sequencer: one result per cycle from the head bundle while the receiver is ready.
    jsu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_qstat (w_qstat),
        .i_ready (i_m_axis_tready),
        .o_pop   (w_pop),
        .o_valid (o_m_axis_tvalid),
        .o_byte  (o_m_axis_tdata),
        .o_has   (w_has),
        .o_end   (w_end),
        .o_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tuser = {w_end, w_has};

    // A status-only result always closes the group of results of its byte.
    `ASSERT_CLK_RST(a_status_is_last, i_clk, i_rst_n, o_m_axis_tvalid && !w_has |-> o_m_axis_tlast, "status result without tlast")
    // A status-only result carries an end kind and a zero byte; data carries no end kind.
    `ASSERT_CLK_RST(a_status_fields, i_clk, i_rst_n, o_m_axis_tvalid |-> (w_has ? (w_end == END_NONE) : (w_end != END_NONE && o_m_axis_tdata == 8'h00)), "end kind does not match has_byte")
    // The decoder never pushes into a full queue.
    `ASSERT_CLK_RST(a_no_overflow, i_clk, i_rst_n, w_push |-> !w_qstat.full, "push into full queue")
    // The output register is empty in the cycle after reset.
    `ASSERT_CLK(a_reset_empty, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "output valid right after reset")

endmodule

`default_nettype wire

// ===== rtl/core/jsu_front.sv =====
// Front end: decodes escapes and turns each input byte into a bundle of result bytes.
`timescale 1ns / 1ps
`default_nettype none

module jsu_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_begin,
    input  wire jsu_pkg::t_qstat i_qstat,
    output logic                 o_ready,
    output logic                 o_push,
    output jsu_pkg::t_cmd        o_cmd
);
    import jsu_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE, PH_TEXT, PH_ESC, PH_HEX, PH_SUR_BS, PH_SUR_U, PH_SUR_HEX
    } t_phase;

    typedef enum logic [1:0] {TAIL_NONE, TAIL_TEXT, TAIL_ESC} t_tail;

    t_phase      r_phase, n_phase;
    logic [15:0] r_acc, n_acc;
    logic [2:0]  r_dc, n_dc;
    logic [9:0]  r_hs, n_hs;
    logic [7:0]  r_held [3];
    logic        w_held_we;
    logic [1:0]  w_held_idx;
    logic        w_accept;
    t_cmd        w_cmd;

    function automatic t_cmd add(input t_cmd c, input logic [7:0] b);
        t_cmd r;
        r = c;
        r.data[c.cnt[RES_IDX_W-1:0]] = b;
        r.cnt = c.cnt + 1'b1;
        return r;
    endfunction

    function automatic t_cmd add_fffd(input t_cmd c);
        t_cmd r;
        r = add(c, 8'hEF);
        r = add(r, 8'hBF);
        r = add(r, 8'hBD);
        return r;
    endfunction

    function automatic t_cmd add_bmp(input t_cmd c, input logic [15:0] cp);
        t_cmd        r;
        logic [15:0] v;
        r = c;
        v = cp;
        if (cp < 16'h0080) begin
            r = add(r, cp[7:0]);
        end else if (cp < 16'h0800) begin
            r = add(r, {3'b110, cp[10:6]});
            r = add(r, {2'b10, cp[5:0]});
        end else begin
            if (cp[15:11] == 5'b11011) begin
                v = 16'hFFFD;
            end
            r = add(r, {4'hE, v[15:12]});
            r = add(r, {2'b10, v[11:6]});
            r = add(r, {2'b10, v[5:0]});
        end
        return r;
    endfunction

    assign o_ready  = !i_qstat.full;
    assign w_accept = i_valid && o_ready;
    assign o_push   = w_accept && (w_cmd.cnt != '0);
    assign o_cmd    = w_cmd;

    always_comb begin
        t_hex        hx;
        t_tail       tail;
        t_cmd        c;
        logic [20:0] cp4;
        n_phase    = r_phase;
        n_acc      = r_acc;
        n_dc       = r_dc;
        n_hs       = r_hs;
        w_held_we  = 1'b0;
        w_held_idx = r_dc[1:0];
        tail       = TAIL_NONE;
        c          = '0;
        cp4        = '0;
        hx         = hex_digit(i_byte);

        if (i_begin) begin
            n_phase = PH_TEXT;
            n_acc   = '0;
            n_dc    = '0;
            n_hs    = '0;
        end

        case (n_phase)
            PH_TEXT: begin
                tail = TAIL_TEXT;
            end
            PH_ESC: begin
                tail = TAIL_ESC;
            end
            PH_HEX, PH_SUR_HEX: begin
                if (!hx.valid) begin
                    if (n_phase == PH_SUR_HEX) begin
                        c = add_fffd(c);
                    end
                    c = add(c, CH_QMARK);
                    for (int i = 0; i < 3; i++) begin
                        if (3'(i) < n_dc) begin
                            c = add(c, r_held[2'(i)]);
                        end
                    end
                    n_phase = PH_TEXT;
                    tail    = TAIL_TEXT;
                end else begin
                    w_held_we  = (n_dc < 3'd3);
                    w_held_idx = n_dc[1:0];
                    n_acc      = {n_acc[11:0], hx.val};
                    n_dc       = n_dc + 3'd1;
                    if (n_dc == 3'd4) begin
                        if (n_phase == PH_SUR_HEX && n_acc[15:10] == 6'b110111) begin
                            cp4 = 21'h10000 + {1'b0, n_hs, n_acc[9:0]};
                            c = add(c, {5'b11110, cp4[20:18]});
                            c = add(c, {2'b10, cp4[17:12]});
                            c = add(c, {2'b10, cp4[11:6]});
                            c = add(c, {2'b10, cp4[5:0]});
                            n_phase = PH_TEXT;
                        end else begin
                            if (n_phase == PH_SUR_HEX) begin
                                c = add_fffd(c);
                            end
                            // A high half waits for its partner; anything else is encoded.
                            if (n_acc[15:10] == 6'b110110) begin
                                n_hs    = n_acc[9:0];
                                n_phase = PH_SUR_BS;
                            end else begin
                                n_phase = PH_TEXT;
                                c = add_bmp(c, n_acc);
                            end
                        end
                    end
                end
            end
            PH_SUR_BS: begin
                if (i_byte == CH_BSLASH) begin
                    n_phase = PH_SUR_U;
                end else begin
                    c       = add_fffd(c);
                    n_phase = PH_TEXT;
                    tail    = TAIL_TEXT;
                end
            end
            PH_SUR_U: begin
                if (i_byte == CH_U) begin
                    n_phase = PH_SUR_HEX;
                    n_dc    = '0;
                    n_acc   = '0;
                end else begin
                    c    = add_fffd(c);
                    tail = TAIL_ESC;
                end
            end
            default: begin
                tail = TAIL_NONE;
            end
        endcase

        case (tail)
            TAIL_TEXT: begin
                if (i_byte == CH_NUL) begin
                    n_phase = PH_IDLE;
                    c       = add(c, 8'h00);
                    c.ekind = END_ZERO;
                end else if (i_byte == CH_QUOTE) begin
                    n_phase = PH_IDLE;
                    c       = add(c, 8'h00);
                    c.ekind = END_QUOTE;
                end else if (i_byte == CH_BSLASH) begin
                    n_phase = PH_ESC;
                end else begin
                    c = add(c, i_byte);
                end
            end
            TAIL_ESC: begin
                n_phase = PH_TEXT;
                case (i_byte)
                    CH_N:    c = add(c, CH_LF);
                    CH_T:    c = add(c, CH_TAB);
                    CH_R:    c = add(c, CH_CR);
                    CH_B:    c = add(c, CH_BS);
                    CH_F:    c = add(c, CH_FF);
                    CH_U: begin
                        n_phase = PH_HEX;
                        n_dc    = '0;
                        n_acc   = '0;
                    end
                    CH_NUL: begin
                        n_phase = PH_IDLE;
                        c       = add(c, 8'h00);
                        c.ekind = END_ZERO;
                    end
                    default: c = add(c, i_byte);
                endcase
            end
            default: begin
                c = c;
            end
        endcase

        w_cmd = c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_acc   <= '0;
            r_dc    <= '0;
            r_hs    <= '0;
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_dc    <= n_dc;
            r_hs    <= n_hs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_held_we) begin
            r_held[w_held_idx] <= i_byte;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/jsu_queue.sv =====
// Short queue of result bundles between the decoder and the output sequencer.
`timescale 1ns / 1ps
`default_nettype none

module jsu_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire jsu_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output jsu_pkg::t_cmd      o_head,
    output jsu_pkg::t_qstat    o_qstat
);
    import jsu_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              w_push, w_pop;

    assign o_qstat.full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign w_push        = i_push && !o_qstat.full;
    assign w_pop         = i_pop && !o_qstat.empty;
    assign o_head        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/jsu_back.sv =====
// Back end: walks the head bundle one result per cycle, while the receiver is ready, into the output register.
`timescale 1ns / 1ps
`default_nettype none

module jsu_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire jsu_pkg::t_cmd   i_head,
    input  wire jsu_pkg::t_qstat i_qstat,
    input  wire logic            i_ready,
    output logic                 o_pop,
    output logic                 o_valid,
    output logic [7:0]           o_byte,
    output logic                 o_has,
    output jsu_pkg::t_end        o_end,
    output logic                 o_last
);
    import jsu_pkg::*;

    logic [RES_IDX_W-1:0] r_idx;
    logic                 r_valid;
    logic [7:0]           r_byte;
    logic                 r_has;
    t_end                 r_end;
    logic                 r_last;
    logic                 w_load, w_last, w_status;

    assign w_load   = !i_qstat.empty && (!r_valid || i_ready);
    assign w_last   = (RES_CNT_W'(r_idx) + 1'b1 == i_head.cnt);
    assign w_status = w_last && (i_head.ekind != END_NONE);
    assign o_pop    = w_load && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_idx   <= w_last ? '0 : r_idx + 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= w_status ? 8'h00 : i_head.data[r_idx];
            r_has  <= !w_status;
            r_end  <= w_status ? i_head.ekind : END_NONE;
            r_last <= w_last;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_has   = r_has;
    assign o_end   = r_end;
    assign o_last  = r_last;

endmodule

`default_nettype wire
